@@ rtl/core/apd_pkg.sv @@
// Package of the audio presence detector: field widths, command, event and
// register codes, and the command/status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package apd_pkg;

   // Default sample width and the fixed field widths.
   localparam int SAMPLE_BITS_DEF = 10;
   localparam int KIND_W          = 2;
   localparam int EVENT_W         = 2;
   localparam int VALUE_W         = 10;
   localparam int TIME_W          = 32;
   localparam int CNT_W           = 16;
   localparam int TOTAL_W         = CNT_W + 1;
   localparam int CAL_CNT_W       = 24;
   localparam int PCT_W           = 7;
   localparam int LEVEL_W         = 10;
   localparam int WINDOW_W        = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 16;
   localparam int OUT_DATA_W      = ((VALUE_W + 7) / 8) * 8;
   localparam int PCT_PROD_W      = CNT_W + PCT_W;
   localparam logic [PCT_PROD_W-1:0] PCT_SCALE = PCT_PROD_W'(100);

   // Kind of an input transaction.
   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_CALIB   = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_STOP    = 2'd3
   } kind_type;

   // Kind of a result transaction.
   typedef enum logic [EVENT_W-1:0] {
      EV_SIGNAL     = 2'd0,
      EV_SILENCE    = 2'd1,
      EV_REPORT     = 2'd2,
      EV_CALIB_DONE = 2'd3
   } event_type;

   // Presence decision.
   typedef enum logic [1:0] {
      PRES_UNKNOWN = 2'd0,
      PRES_SIGNAL  = 2'd1,
      PRES_SILENCE = 2'd2
   } presence_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ZERO_LEVEL    = 3'd0,
      REG_SENSITIVITY   = 3'd1,
      REG_THRESHOLD     = 3'd2,
      REG_INTERVAL      = 3'd3,
      REG_SIGNAL_WIN    = 3'd4,
      REG_SILENCE_WIN   = 3'd5,
      REG_CALIB_TIMEOUT = 3'd6
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // capture the input transaction
      logic apply_ctl;    // execute a calibrate, restart or stop command
      logic accumulate;   // add the sample to the calibration sum
      logic measure;      // count the sample loud or quiet
      logic start_pct;    // start percentage and window divisions
      logic start_mean;   // start the calibration mean division
      logic decide;       // take decisions and fill the result buffer
      logic finish_mean;  // place the mean in the result buffer and restart
      logic push;         // move a buffered result to the output register
      logic push_idx;     // which buffered result to move
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       is_ctl;
      logic       stopped;
      logic       calibrating;
      logic       calib_running;
      logic       interval_ok;
      logic       div_done;
      logic [1:0] res_count;
      logic       out_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/core/audio_presence_detector.sv @@
// Audio presence detector: a sample stream goes in, signal, silence, report and
// calibration events come out. One item is in work at a time. A measured
// sample spends most of its time in the shared restoring divider that produces
// the loud percentage one bit per cycle over SAMPLE_BITS + 24 bits, with the
// two window residues computed beside it; the end of a calibration run uses
// the same divider. Results wait in an output register, so a new item is
// accepted while the last result of the previous one is still pending; any
// other result waits, and holds the input off, for as long as that register
// stays full.
// Depends on apd_pkg, apd_ctrl, apd_datapath and apd_divider.
`default_nettype none

module audio_presence_detector #(
   parameter int SAMPLE_BITS = apd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // Input stream.
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata: sample [SAMPLE_BITS-1:0], now_ms [SAMPLE_BITS+31:SAMPLE_BITS], zero fill
   input  wire logic [((SAMPLE_BITS + apd_pkg::TIME_W + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: kind [1:0]
   input  wire logic [apd_pkg::KIND_W-1:0] req_tuser,
   // Result stream.
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata: value [9:0], zero fill
   output logic [apd_pkg::OUT_DATA_W-1:0] rsp_tdata,
   // tuser: event_res [1:0]
   output logic [apd_pkg::EVENT_W-1:0] rsp_tuser,
   output logic      rsp_tlast,
   // Configuration write channel.
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [apd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [apd_pkg::CSR_DATA_W-1:0]  csr_data
);

   import apd_pkg::*;

   cmd_type            cmd;
   status_type         status;
   event_type          rsp_event;
   logic [VALUE_W-1:0] rsp_value;

   assign csr_ready = 1'b1;

   apd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   apd_datapath #(.SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_kind   (req_tuser),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .in_now    (req_tdata[SAMPLE_BITS+TIME_W-1:SAMPLE_BITS]),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_event (rsp_event),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tuser = rsp_event;
   assign rsp_tdata = OUT_DATA_W'(rsp_value);

   // An item is taken only when no division is running.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> status.div_done)
      else $error("input transaction accepted during a division");

   // A result is moved only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> status.out_free)
      else $error("result pushed over a pending result");

   // A percentage division is in progress in the cycle after it starts.
   assert property (@(posedge clock) disable iff (reset)
      cmd.start_pct |=> !status.div_done)
      else $error("divider did not start");

   // The end of a calibration run is always the only result of its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == EV_CALIB_DONE)) |-> rsp_tlast)
      else $error("calibration result without last flag");

endmodule

`default_nettype wire

@@ rtl/core/apd_divider.sv @@
// Restoring divider, one quotient bit per cycle, N quotient bits per division.
// Depends on nothing.
`default_nettype none

module apd_divider #(
   parameter int N = 34,
   parameter int D = 24
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [N-1:0] dividend,
   input  wire logic [D-1:0] divisor,
   output logic              busy,
   output logic [N-1:0]      quotient,
   output logic [D-1:0]      remainder
);

   localparam int CW = $clog2(N + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [D-1:0]  div_ff, div_in;
   logic [D:0]    shifted;
   logic [D:0]    trial;

   // One shift-and-subtract step per cycle while the count runs.
   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      shifted = {rem_ff, quo_ff[N-1]};
      trial   = shifted - {1'b0, div_ff};
      if (start) begin
         cnt_in = CW'(N);
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[D]) begin
            rem_in = trial[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = shifted[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
      end
   end

   // The operands are cleared at reset so the outputs are known before the
   // first division.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         quo_ff <= '0;
         rem_ff <= '0;
         div_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         div_ff <= div_in;
      end
   end

   assign busy      = (cnt_ff != '0);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ rtl/core/apd_ctrl.sv @@
// Controller state machine of the audio presence detector.
// Depends on apd_pkg; drives the datapath through cmd_type, reads status_type.
`default_nettype none

module apd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire apd_pkg::status_type status,
   output apd_pkg::cmd_type         cmd
);

   import apd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_PCT_START,
      S_PCT_WAIT,
      S_DECIDE,
      S_MEAN_WAIT,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      push_idx_ff, push_idx_in;
   logic      push_is_last;

   assign push_is_last = ({1'b0, push_idx_ff} + 2'd1) == status.res_count;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      push_idx_in  = push_idx_ff;
      cmd          = '0;
      cmd.push_idx = push_idx_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.is_ctl) begin
               cmd.apply_ctl = 1'b1;
               state_in      = S_IDLE;
            end else if (status.stopped) begin
               state_in = S_IDLE;
            end else if (status.calibrating) begin
               if (status.calib_running) begin
                  cmd.accumulate = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  cmd.start_mean = 1'b1;
                  state_in       = S_MEAN_WAIT;
               end
            end else if (status.interval_ok) begin
               cmd.measure = 1'b1;
               state_in    = S_PCT_START;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PCT_START: begin
            cmd.start_pct = 1'b1;
            state_in      = S_PCT_WAIT;
         end
         S_PCT_WAIT: begin
            if (status.div_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide  = 1'b1;
            push_idx_in = 1'b0;
            state_in    = S_PUSH;
         end
         S_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.finish_mean = 1'b1;
               push_idx_in     = 1'b0;
               state_in        = S_PUSH;
            end
         end
         S_PUSH: begin
            if (status.res_count == 2'd0) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.push = 1'b1;
               if (push_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  push_idx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and push index.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         push_idx_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         push_idx_ff <= push_idx_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/apd_datapath.sv @@
// Datapath of the audio presence detector: configuration registers, counters,
// calibration accumulator, dividers, result buffer and output register.
// Depends on apd_pkg and apd_divider.
`default_nettype none

module apd_datapath #(
   parameter int SAMPLE_BITS = apd_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Configuration writes.
   input  wire logic                             csr_write,
   input  wire logic [apd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [apd_pkg::CSR_DATA_W-1:0]   csr_data,
   // Input fields.
   input  wire logic [apd_pkg::KIND_W-1:0]       in_kind,
   input  wire logic [SAMPLE_BITS-1:0]           in_sample,
   input  wire logic [apd_pkg::TIME_W-1:0]       in_now,
   // Controller interface.
   input  wire apd_pkg::cmd_type                 cmd,
   output apd_pkg::status_type                   status,
   // Result register.
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output apd_pkg::event_type                    rsp_event,
   output logic [apd_pkg::VALUE_W-1:0]           rsp_value,
   output logic                                  rsp_last
);

   import apd_pkg::*;

   localparam int CSUM_W = SAMPLE_BITS + CAL_CNT_W;
   localparam int DEV_W  = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

   // Configuration registers.
   logic [LEVEL_W-1:0]  zero_level_ff;
   logic [LEVEL_W-1:0]  sensitivity_ff;
   logic [PCT_W-1:0]    threshold_ff;
   logic [WINDOW_W-1:0] interval_ff;
   logic [WINDOW_W-1:0] signal_win_ff;
   logic [WINDOW_W-1:0] silence_win_ff;
   logic [WINDOW_W-1:0] calib_timeout_ff;

   // Captured input transaction.
   kind_type               kind_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [TIME_W-1:0]      now_ff;

   // Detector state.
   logic                 stopped_ff;
   logic                 calibrating_ff;
   presence_type         presence_ff;
   logic [CNT_W-1:0]     loud_ff;
   logic [CNT_W-1:0]     quiet_ff;
   logic [TIME_W-1:0]    last_meas_ff;
   logic [TIME_W-1:0]    cal_start_ff;
   logic [CSUM_W-1:0]    cal_sum_ff;
   logic [CAL_CNT_W-1:0] cal_cnt_ff;

   // Result buffer and output register.
   event_type          res_ev0_ff;
   event_type          res_ev1_ff;
   logic [VALUE_W-1:0] res_value_ff;
   logic [1:0]         res_count_ff;
   logic               rsp_valid_ff;
   event_type          rsp_event_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_last_ff;

   // Derived values.
   logic [DEV_W-1:0]      smp_ext;
   logic [DEV_W-1:0]      zero_ext;
   logic [DEV_W-1:0]      dev;
   logic                  is_loud;
   logic [TIME_W-1:0]     since_meas;
   logic [TIME_W-1:0]     since_cal;
   logic [WINDOW_W-1:0]   sw_eff;
   logic [WINDOW_W-1:0]   qw_eff;
   logic [WINDOW_W-1:0]   win_max;
   logic [TOTAL_W-1:0]    total;
   logic [PCT_PROD_W-1:0] loud_scaled;

   // Divider connections.
   logic                 main_start;
   logic [CSUM_W-1:0]    main_dividend;
   logic [CAL_CNT_W-1:0] main_divisor;
   logic                 main_busy;
   logic [CSUM_W-1:0]    main_quo;
   logic [CAL_CNT_W-1:0] main_rem;
   logic                 sw_busy;
   logic [TOTAL_W-1:0]   sw_quo;
   logic [WINDOW_W-1:0]  sw_rem;
   logic                 qw_busy;
   logic [TOTAL_W-1:0]   qw_quo;
   logic [WINDOW_W-1:0]  qw_rem;

   // Decision logic.
   logic [PCT_W-1:0]   pct;
   logic [VALUE_W-1:0] mean;
   logic               fire_sig;
   logic               fire_sil;
   logic               fire_rep;

   assign smp_ext    = DEV_W'(sample_ff);
   assign zero_ext   = DEV_W'(zero_level_ff);
   assign dev        = (smp_ext >= zero_ext) ? smp_ext - zero_ext : zero_ext - smp_ext;
   assign is_loud    = dev > DEV_W'(sensitivity_ff);
   assign since_meas = now_ff - last_meas_ff;
   assign since_cal  = now_ff - cal_start_ff;
   assign sw_eff     = (signal_win_ff == '0) ? WINDOW_W'(1) : signal_win_ff;
   assign qw_eff     = (silence_win_ff == '0) ? WINDOW_W'(1) : silence_win_ff;
   assign win_max    = (sw_eff > qw_eff) ? sw_eff : qw_eff;
   assign total      = TOTAL_W'(loud_ff) + TOTAL_W'(quiet_ff);
   assign loud_scaled = PCT_PROD_W'(loud_ff) * PCT_SCALE;

   // The main divider serves the percentage and the calibration mean.
   assign main_start    = cmd.start_pct | cmd.start_mean;
   assign main_dividend = cmd.start_mean ? cal_sum_ff : CSUM_W'(loud_scaled);
   assign main_divisor  = cmd.start_mean ? cal_cnt_ff : CAL_CNT_W'(total);

   apd_divider #(.N(CSUM_W), .D(CAL_CNT_W)) u_div_main (
      .clock     (clock),
      .reset     (reset),
      .start     (main_start),
      .dividend  (main_dividend),
      .divisor   (main_divisor),
      .busy      (main_busy),
      .quotient  (main_quo),
      .remainder (main_rem)
   );

   // Window residues run beside the percentage division.
   apd_divider #(.N(TOTAL_W), .D(WINDOW_W)) u_div_sw (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_pct),
      .dividend  (total),
      .divisor   (sw_eff),
      .busy      (sw_busy),
      .quotient  (sw_quo),
      .remainder (sw_rem)
   );

   apd_divider #(.N(TOTAL_W), .D(WINDOW_W)) u_div_qw (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_pct),
      .dividend  (total),
      .divisor   (qw_eff),
      .busy      (qw_busy),
      .quotient  (qw_quo),
      .remainder (qw_rem)
   );

   // Decisions from the finished divisions. The quotients of the window
   // divisions and the main remainder are not needed.
   assign pct      = main_quo[PCT_W-1:0];
   assign mean     = (cal_cnt_ff == '0) ? '0 : main_quo[VALUE_W-1:0];
   assign fire_sig = (sw_rem == '0) && (presence_ff != PRES_SIGNAL) && (pct >= threshold_ff);
   assign fire_sil = (qw_rem == '0) && (presence_ff != PRES_SILENCE) && (pct < threshold_ff);
   assign fire_rep = (total == TOTAL_W'(win_max));

   // Status to the controller.
   assign status.is_ctl        = (kind_ff != KIND_SAMPLE);
   assign status.stopped       = stopped_ff;
   assign status.calibrating   = calibrating_ff;
   assign status.calib_running = since_cal < TIME_W'(calib_timeout_ff);
   assign status.interval_ok   = !(since_meas < TIME_W'(interval_ff));
   assign status.div_done      = !main_busy && !sw_busy && !qw_busy
                                 && (sw_quo == sw_quo) && (qw_quo == qw_quo)
                                 && (main_rem == main_rem);
   assign status.res_count     = res_count_ff;
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_level_ff    <= LEVEL_W'(512);
         sensitivity_ff   <= '0;
         threshold_ff     <= PCT_W'(50);
         interval_ff      <= '0;
         signal_win_ff    <= WINDOW_W'(1);
         silence_win_ff   <= WINDOW_W'(1);
         calib_timeout_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            REG_ZERO_LEVEL:    zero_level_ff    <= csr_data[LEVEL_W-1:0];
            REG_SENSITIVITY:   sensitivity_ff   <= csr_data[LEVEL_W-1:0];
            REG_THRESHOLD:     threshold_ff     <= csr_data[PCT_W-1:0];
            REG_INTERVAL:      interval_ff      <= csr_data[WINDOW_W-1:0];
            REG_SIGNAL_WIN:    signal_win_ff    <= csr_data[WINDOW_W-1:0];
            REG_SILENCE_WIN:   silence_win_ff   <= csr_data[WINDOW_W-1:0];
            REG_CALIB_TIMEOUT: calib_timeout_ff <= csr_data[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Captured input fields.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= kind_type'(in_kind);
         sample_ff <= in_sample;
         now_ff    <= in_now;
      end
   end

   // Detector state and result buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff     <= 1'b1;
         calibrating_ff <= 1'b0;
         presence_ff    <= PRES_UNKNOWN;
         loud_ff        <= '0;
         quiet_ff       <= '0;
         last_meas_ff   <= '0;
         cal_start_ff   <= '0;
         cal_sum_ff     <= '0;
         cal_cnt_ff     <= '0;
         res_count_ff   <= 2'd0;
      end else begin
         // Calibrate, restart and stop commands.
         if (cmd.apply_ctl) begin
            case (kind_ff)
               KIND_CALIB: begin
                  calibrating_ff <= 1'b1;
                  cal_sum_ff     <= '0;
                  cal_cnt_ff     <= '0;
                  cal_start_ff   <= now_ff;
               end
               KIND_RESTART: begin
                  loud_ff        <= '0;
                  quiet_ff       <= '0;
                  presence_ff    <= PRES_UNKNOWN;
                  calibrating_ff <= 1'b0;
                  last_meas_ff   <= now_ff;
                  stopped_ff     <= 1'b0;
               end
               KIND_STOP: begin
                  presence_ff <= PRES_UNKNOWN;
                  stopped_ff  <= 1'b1;
               end
               default: begin
               end
            endcase
         end

         // Calibration accumulation stops once the count is full.
         if (cmd.accumulate && (cal_cnt_ff != '1)) begin
            cal_sum_ff <= cal_sum_ff + CSUM_W'(sample_ff);
            cal_cnt_ff <= cal_cnt_ff + 1'b1;
         end

         // Saturating loud and quiet counts.
         if (cmd.measure) begin
            last_meas_ff <= now_ff;
            if (is_loud) begin
               if (loud_ff != '1) begin
                  loud_ff <= loud_ff + 1'b1;
               end
            end else if (quiet_ff != '1) begin
               quiet_ff <= quiet_ff + 1'b1;
            end
         end

         // Signal or silence decision first, then the report.
         if (cmd.decide) begin
            res_value_ff <= VALUE_W'(pct);
            res_ev1_ff   <= EV_REPORT;
            if (fire_sig) begin
               presence_ff <= PRES_SIGNAL;
               res_ev0_ff  <= EV_SIGNAL;
            end else if (fire_sil) begin
               presence_ff <= PRES_SILENCE;
               res_ev0_ff  <= EV_SILENCE;
            end else begin
               res_ev0_ff <= EV_REPORT;
            end
            res_count_ff <= 2'({1'b0, fire_sig | fire_sil} + {1'b0, fire_rep});
            if (fire_rep) begin
               loud_ff  <= '0;
               quiet_ff <= '0;
            end
         end

         // End of calibration: report the mean and restart.
         if (cmd.finish_mean) begin
            res_value_ff   <= mean;
            res_ev0_ff     <= EV_CALIB_DONE;
            res_count_ff   <= 2'd1;
            loud_ff        <= '0;
            quiet_ff       <= '0;
            presence_ff    <= PRES_UNKNOWN;
            calibrating_ff <= 1'b0;
            last_meas_ff   <= now_ff;
            stopped_ff     <= 1'b0;
         end
      end
   end

   // Output register: loaded from the buffer, emptied by a transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.push) begin
         rsp_event_ff <= cmd.push_idx ? res_ev1_ff : res_ev0_ff;
         rsp_value_ff <= res_value_ff;
         rsp_last_ff  <= ({1'b0, cmd.push_idx} + 2'd1) == res_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event = rsp_event_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire
